>>> rtl/hbp_pkg.sv
// Shared types and constants of the Huffman table bit packer.
// Used by every module of the block; depends on nothing else.
`default_nettype none

package hbp_pkg;

	localparam int BYTE_W = 8;
	localparam int CODE_IN_W = 32;
	localparam int COUNT_W = 24;
	localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

	localparam logic [1:0] CMD_LOAD = 2'd0;
	localparam logic [1:0] CMD_ENCODE = 2'd1;
	localparam logic [1:0] CMD_FINISH = 2'd2;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_END = 1'b1;

	typedef struct packed {
		logic [1:0] cmd;
		logic [7:0] symbol;
		logic [31:0] code_bits;
		logic [5:0] code_length;
	} item_t;

	typedef struct packed {
		logic kind;
		logic [7:0] out_byte;
		logic has_partial;
		logic [3:0] last_valid_bits;
		logic [23:0] byte_count;
	} result_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_PACK,
		ST_FINISH
	} state_t;

	typedef struct packed {
		logic wr_entry;
		logic rd_entry;
		logic align;
		logic step;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic in_range;
		logic len_zero;
		logic step_fills;
		logic step_last;
		logic slot_free;
	} ctl_status_t;

endpackage

`default_nettype wire

>>> rtl/hbp_ctrl.sv
// Controller state machine of the Huffman table bit packer.
// Depends on hbp_pkg; drives the datapath through ctl_cmd_t.
`default_nettype none

module hbp_ctrl
	import hbp_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        item_valid,
	input  wire logic [1:0]  item_cmd,
	input  wire ctl_status_t status,
	output logic             item_stall,
	output ctl_cmd_t         ctl
);

	state_t state_q;
	state_t state_next;
	logic   accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_next;
		end
	end

	always_comb begin
		state_next = state_q;
		item_stall = 1'b1;
		ctl = '0;
		accept = 1'b0;
		case (state_q)
			ST_IDLE: begin
				item_stall = 1'b0;
				accept = item_valid;
				if (accept) begin
					case (item_cmd)
						CMD_LOAD: begin
							ctl.wr_entry = status.in_range;
						end
						CMD_ENCODE: begin
							if (status.in_range) begin
								ctl.rd_entry = 1'b1;
								state_next = ST_LOOKUP;
							end
						end
						CMD_FINISH: begin
							state_next = ST_FINISH;
						end
						default: begin
						end
					endcase
				end
			end
			ST_LOOKUP: begin
				ctl.align = 1'b1;
				state_next = status.len_zero ? ST_IDLE : ST_PACK;
			end
			ST_PACK: begin
				// A step that completes a byte waits until the output word is free.
				ctl.step = !status.step_fills || status.slot_free;
				if (ctl.step && status.step_last) begin
					state_next = ST_IDLE;
				end
			end
			ST_FINISH: begin
				if (status.slot_free) begin
					ctl.finish = 1'b1;
					state_next = ST_IDLE;
				end
			end
			default: begin
				state_next = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

>>> rtl/hbp_datapath.sv
// Datapath of the Huffman table bit packer: code table, bit accumulator,
// byte counter and output word register. Depends on hbp_pkg.
`default_nettype none

module hbp_datapath
	import hbp_pkg::*;
#(
	parameter int NUM_SYMBOLS = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire item_t   item,
	input  wire ctl_cmd_t ctl,
	input  wire logic    result_stall,
	output ctl_status_t  status,
	output logic         result_valid,
	output result_t      result
);

	localparam int CODE_W = (MAX_CODE_LEN < CODE_IN_W) ? MAX_CODE_LEN : CODE_IN_W;
	localparam int SYM_W = (NUM_SYMBOLS > 2) ? $clog2(NUM_SYMBOLS) : 1;
	localparam logic [5:0] LEN_CAP = 6'(CODE_W);
	localparam logic [8:0] SYM_LIMIT = 9'(NUM_SYMBOLS);

	logic [CODE_W-1:0] mem_code [NUM_SYMBOLS];
	logic [5:0]        mem_len [NUM_SYMBOLS];
	logic [NUM_SYMBOLS-1:0] entry_valid_q;

	logic [SYM_W-1:0]  idx;
	logic [5:0]        len_capped;
	logic [CODE_W-1:0] rd_code_q;
	logic [5:0]        rd_len_q;
	logic              rd_hit_q;
	logic [5:0]        eff_len;

	logic [CODE_W-1:0] code_sh_q;
	logic [5:0]        rem_q;
	logic [7:0]        pend_q;
	logic [2:0]        pos_q;
	logic [COUNT_W-1:0] bytes_q;

	logic [3:0]        room;
	logic [3:0]        take;
	logic [7:0]        merged;
	logic              partial;
	logic              res_valid_q;
	result_t           res_q;

	assign idx = item.symbol[SYM_W-1:0];
	assign len_capped = (item.code_length > LEN_CAP) ? LEN_CAP : item.code_length;
	assign eff_len = rd_hit_q ? rd_len_q : 6'd0;

	// Table storage; an entry never loaded reads as length zero via its valid bit.
	always_ff @(posedge clk) begin
		if (ctl.wr_entry) begin
			mem_code[idx] <= item.code_bits[CODE_W-1:0];
			mem_len[idx] <= len_capped;
		end
		if (ctl.rd_entry) begin
			rd_code_q <= mem_code[idx];
			rd_len_q <= mem_len[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_valid_q <= '0;
			rd_hit_q <= 1'b0;
		end else begin
			if (ctl.wr_entry) begin
				entry_valid_q[idx] <= 1'b1;
			end
			if (ctl.rd_entry) begin
				rd_hit_q <= entry_valid_q[idx];
			end
		end
	end

	// Each step moves as many code bits as fit in the pending byte.
	assign room = 4'd8 - {1'b0, pos_q};
	assign take = (rem_q < {2'b00, room}) ? rem_q[3:0] : room;
	assign merged = pend_q | (code_sh_q[CODE_W-1 -: BYTE_W] >> pos_q);
	assign partial = (pos_q != 3'd0);

	always_ff @(posedge clk) begin
		if (ctl.align) begin
			code_sh_q <= rd_code_q << (LEN_CAP - eff_len);
		end else if (ctl.step) begin
			code_sh_q <= code_sh_q << take;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q <= '0;
			pend_q <= '0;
			pos_q <= '0;
			bytes_q <= '0;
		end else begin
			if (ctl.align) begin
				rem_q <= eff_len;
			end else if (ctl.step) begin
				rem_q <= rem_q - {2'b00, take};
				if (take == room) begin
					pend_q <= '0;
					pos_q <= '0;
					if (bytes_q != COUNT_MAX) begin
						bytes_q <= bytes_q + 1'b1;
					end
				end else begin
					pend_q <= merged;
					pos_q <= pos_q + take[2:0];
				end
			end else if (ctl.finish) begin
				pend_q <= '0;
				pos_q <= '0;
				bytes_q <= '0;
			end
		end
	end

	// Output word register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if ((ctl.step && take == room) || ctl.finish) begin
			res_valid_q <= 1'b1;
		end else if (!result_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.step && take == room) begin
			res_q.kind <= KIND_DATA;
			res_q.out_byte <= merged;
			res_q.has_partial <= 1'b0;
			res_q.last_valid_bits <= 4'd8;
			res_q.byte_count <= '0;
		end else if (ctl.finish) begin
			res_q.kind <= KIND_END;
			res_q.out_byte <= pend_q;
			res_q.has_partial <= partial;
			res_q.last_valid_bits <= partial ? {1'b0, pos_q} : 4'd8;
			res_q.byte_count <= (partial && bytes_q != COUNT_MAX) ? bytes_q + 1'b1 : bytes_q;
		end
	end

	assign result_valid = res_valid_q;
	assign result = res_q;

	assign status.in_range = ({1'b0, item.symbol} < SYM_LIMIT);
	assign status.len_zero = (eff_len == 6'd0);
	assign status.step_fills = (take == room);
	assign status.step_last = ({2'b00, take} == rem_q);
	assign status.slot_free = !res_valid_q || !result_stall;

endmodule

`default_nettype wire

>>> rtl/huffman_table_bit_packer.sv
// Huffman table bit packer, top level. Joins hbp_ctrl and hbp_datapath.
// Depends on hbp_pkg.
//
// A load word writes one entry of the code table. An encode word passes through a
// registered table read, a step that left-aligns the code, and then one packing
// step per byte the code touches: between 1 and 5 steps for a code of 1 to 32
// bits, none for a code of length zero. Every step that completes a byte waits
// while the output word is still held by a stalled receiver. A finish word waits
// until the output word is free and then emits the end word. The code table keeps
// one valid bit per entry, so it reads as empty right after reset and needs no
// clearing pass.
`default_nettype none

module huffman_table_bit_packer
	import hbp_pkg::*;
#(
	parameter int NUM_SYMBOLS = 256,
	parameter int MAX_CODE_LEN = 32
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  item_valid,
	output logic       item_stall,
	input  wire item_t item,
	output logic       result_valid,
	input  wire logic  result_stall,
	output result_t    result
);

	ctl_cmd_t    ctl;
	ctl_status_t status;

	hbp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_cmd   (item.cmd),
		.status     (status),
		.item_stall (item_stall),
		.ctl        (ctl)
	);

	hbp_datapath #(
		.NUM_SYMBOLS  (NUM_SYMBOLS),
		.MAX_CODE_LEN (MAX_CODE_LEN)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.item         (item),
		.ctl          (ctl),
		.result_stall (result_stall),
		.status       (status),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

`default_nettype wire

>>> rtl/hbp_checker.sv
// Port-level checks of the Huffman table bit packer, bound to the top level.
// Depends on hbp_pkg.
`default_nettype none

module hbp_checker
	import hbp_pkg::*;
(
	input wire logic    clk,
	input wire logic    arst_n,
	input wire logic    item_valid,
	input wire logic    item_stall,
	input wire item_t   item,
	input wire logic    result_valid,
	input wire logic    result_stall,
	input wire result_t result
);

	// A stalled result word holds until it is taken.
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid && $stable(result))
		else $error("result word changed while stalled");

	// Data words carry the fixed end-of-stream fields.
	a_data_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_DATA |->
		!result.has_partial && result.last_valid_bits == 4'd8 && result.byte_count == '0)
		else $error("data word with end-of-stream fields set");

	// An end word is consistent about its partial byte.
	a_end_fields: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result.kind == KIND_END |->
		(result.has_partial && result.last_valid_bits != 4'd0 &&
			result.last_valid_bits < 4'd8 && result.byte_count != '0) ||
		(!result.has_partial && result.last_valid_bits == 4'd8 && result.out_byte == 8'd0))
		else $error("end word with inconsistent partial byte");

	// A finish word always keeps the input stalled for the following cycle.
	a_finish_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && !item_stall && item.cmd == CMD_FINISH |=> item_stall)
		else $error("input taken right after a finish word");

endmodule

bind huffman_table_bit_packer hbp_checker u_hbp_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.item_valid   (item_valid),
	.item_stall   (item_stall),
	.item         (item),
	.result_valid (result_valid),
	.result_stall (result_stall),
	.result       (result)
);

`default_nettype wire
